@@ src/mmp_pkg.sv @@
// ----------------------------------------------------------------------------
// mmp_pkg: shared types, constants and helpers of the multi-mode PRNG
// Mode and request codes, generator constants, the rejected-seed list of the
// masked Galois mode, and the folding reduction modulo 65535.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

  typedef enum logic [1:0] {
    MODE_FIB    = 2'd0,
    MODE_LCG    = 2'd1,
    MODE_GALOIS = 2'd2,
    MODE_PM     = 2'd3
  } mode_t;

  typedef enum logic {
    REQ_NEXT = 1'b0,
    REQ_SEED = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [15:0] seed;
  } req_t;

  // Fibonacci LFSR: parity table indexed by {s15, s14, s3, s12}
  localparam logic [15:0] FIB_PARITY   = 16'h6996;
  // LCG
  localparam logic [31:0] LCG_MULT     = 32'd1103515245;
  localparam logic [31:0] LCG_INC      = 32'd12345;
  localparam logic [31:0] LCG_RESET    = 32'd1;
  localparam logic [15:0] MOD_BASE     = 16'hFFFF;
  // Galois LFSR
  localparam logic [15:0] GALOIS_POLY  = 16'h100B;
  localparam logic [13:0] GALOIS_SCALE = 14'(119 * 119);
  localparam logic [15:0] MASK_SCALE   = 16'(137 * 29);
  localparam logic [15:0] MASK_RESET   = 16'(137 * 29);
  // Park-Miller
  localparam logic [15:0] PM_MULT      = 16'd33614;
  localparam logic [30:0] SHIFT_RESET  = 31'd1;

  localparam int unsigned BAD_SEED_COUNT = 48;

  localparam logic [15:0] BAD_SEEDS [BAD_SEED_COUNT] = '{
    16'h06d4, 16'h1744, 16'h19d0, 16'h1ccc, 16'h1cfa, 16'h1f79, 16'h2040, 16'h2ee4,
    16'h3362, 16'h3914, 16'h3ac4, 16'h3c25, 16'h4ee4, 16'h4fb9, 16'h56e4, 16'h57c4,
    16'h5c40, 16'h5ecc, 16'h653a, 16'h72d4, 16'h77ec, 16'h7bfa, 16'h82d4, 16'h8759,
    16'h8ad4, 16'h9744, 16'h9e40, 16'ha039, 16'ha0cc, 16'ha4cc, 16'ha704, 16'hac3a,
    16'hb6c4, 16'hbcc0, 16'hbdcc, 16'hbec4, 16'hc4d4, 16'hd2e4, 16'hd875, 16'hdac2,
    16'hdc7a, 16'hddfa, 16'he3d9, 16'he704, 16'hef04, 16'hef39, 16'hf8c4, 16'hfd40
  };

  // Parallel compare against the rejected-seed list
  function automatic logic is_bad_seed(input logic [15:0] s);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < BAD_SEED_COUNT; i++) begin
      if (BAD_SEEDS[i] == s) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // x mod 65535 by folding: 2^16 == 1 (mod 65535)
  function automatic logic [15:0] mod_ffff(input logic [31:0] x);
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] r;
    fold1 = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    r     = fold2[15:0];
    return (r == MOD_BASE) ? 16'd0 : r;
  endfunction

endpackage

`default_nettype wire

@@ src/mmp_gen.sv @@
// ----------------------------------------------------------------------------
// mmp_gen: generator state and one-step update
// Holds the shift state, the Galois output mask and the LCG state. Given the
// item in the input register it forms the raw result and, on fire, commits
// the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module mmp_gen (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mmp_pkg::mode_t mode,
  input  wire logic           fire,
  input  wire mmp_pkg::req_t  req,
  output logic [31:0]         raw
);

  logic [30:0] shift_state;
  logic [30:0] shift_state_next;
  logic [15:0] xor_mask;
  logic [15:0] xor_mask_next;
  logic [31:0] lcg_state;
  logic [31:0] lcg_state_next;

  logic [15:0] s16;
  logic [3:0]  fib_sel;
  logic [15:0] fib_next;
  logic [15:0] gal_shift;
  logic [15:0] gal_next;
  logic [31:0] lcg_step;
  logic [46:0] pm_prod;
  logic [31:0] pm_sum;
  logic [30:0] pm_next;
  logic [29:0] gal_seed_state;
  logic [31:0] mask_prod;

  function automatic logic FIB_PARITY_BIT(input logic [3:0] sel);
    return mmp_pkg::FIB_PARITY[sel];
  endfunction

  assign s16 = shift_state[15:0];

  // Fibonacci: feedback is parity of bits 15, 14, 12, 3
  assign fib_sel  = {s16[15], s16[14], s16[3], s16[12]};
  assign fib_next = {s16[14:0], FIB_PARITY_BIT(fib_sel)};

  // Galois: shift, conditional polynomial, plus one
  assign gal_shift = {s16[14:0], 1'b0} ^ (s16[15] ? mmp_pkg::GALOIS_POLY : 16'd0);
  assign gal_next  = gal_shift + 16'd1;

  // LCG, wraps at 32 bits
  assign lcg_step = lcg_state * mmp_pkg::LCG_MULT + mmp_pkg::LCG_INC;

  // Park-Miller split-add: hi + lo, end-around carry
  assign pm_prod = 47'(mmp_pkg::PM_MULT) * 47'(shift_state);
  assign pm_sum  = 32'(pm_prod[46:32]) + 32'(pm_prod[31:1]);
  assign pm_next = pm_sum[31] ? (pm_sum[30:0] + 31'd1) : pm_sum[30:0];

  // Galois seeding
  assign gal_seed_state = 30'(mmp_pkg::GALOIS_SCALE) * 30'(req.seed);
  assign mask_prod      = 32'(mmp_pkg::MASK_SCALE) * 32'(req.seed);

  always_comb begin
    shift_state_next = shift_state;
    xor_mask_next    = xor_mask;
    lcg_state_next   = lcg_state;
    raw              = '0;
    if (req.kind == mmp_pkg::REQ_SEED) begin
      unique case (mode)
        mmp_pkg::MODE_FIB:    shift_state_next = 31'(req.seed);
        mmp_pkg::MODE_LCG:    lcg_state_next   = 32'(req.seed);
        mmp_pkg::MODE_GALOIS: begin
          if (!mmp_pkg::is_bad_seed(req.seed)) begin
            shift_state_next = 31'(gal_seed_state);
            xor_mask_next    = mask_prod[15:0];
          end
        end
        mmp_pkg::MODE_PM:     shift_state_next = 31'(req.seed) + 31'd1;
      endcase
    end else begin
      unique case (mode)
        mmp_pkg::MODE_FIB: begin
          shift_state_next = 31'(fib_next);
          raw              = 32'(fib_next);
        end
        mmp_pkg::MODE_LCG: begin
          lcg_state_next = lcg_step;
          raw            = lcg_step;
        end
        mmp_pkg::MODE_GALOIS: begin
          shift_state_next = 31'(gal_next);
          raw              = 32'(gal_next ^ xor_mask);
        end
        mmp_pkg::MODE_PM: begin
          shift_state_next = pm_next;
          raw              = 32'(pm_next[15:0]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_state <= mmp_pkg::SHIFT_RESET;
      xor_mask    <= mmp_pkg::MASK_RESET;
      lcg_state   <= mmp_pkg::LCG_RESET;
    end else if (fire) begin
      shift_state <= shift_state_next;
      xor_mask    <= xor_mask_next;
      lcg_state   <= lcg_state_next;
    end
  end

endmodule

`default_nettype wire

@@ src/multi_mode_prng.sv @@
// ----------------------------------------------------------------------------
// multi_mode_prng: four-mode pseudo-random generator
// Each item either loads a seed (no result) or asks for the next 16-bit
// value (one result). The mode register picks a 16-bit Fibonacci LFSR, a
// 32-bit LCG reduced mod 65535, a masked 16-bit Galois LFSR, or the 31-bit
// Park-Miller generator. The block takes one item per cycle, back to back,
// while out_stall is low: an item sits in the input register, the state
// update needs one constant multiply at most, the raw value is registered,
// and the mod-65535 fold is done on the way into the output register.
// Stalls back up through the three stages; with out_stall low, in_stall
// stays low. Write mode only while the block is idle; the shift state is
// shared by the Fibonacci, Galois and Park-Miller modes, and all state is
// kept across mode changes.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_mode_prng (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [15:0] seed,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      value
);

  mmp_pkg::mode_t mode;

  // stage A: input register
  logic           a_valid;
  mmp_pkg::req_t  a_req;
  // stage B: raw result of a next-value item
  logic           b_valid;
  logic [31:0]    b_raw;
  logic           b_lcg;

  logic           a_ready;
  logic           b_ready;
  logic           c_ready;
  logic           fire;
  logic [31:0]    raw;

  // --- stage handshake: each stage moves when its successor has room ---
  assign c_ready  = !out_valid || !out_stall;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_stall = !a_ready;
  // item in A commits its state update
  assign fire     = a_valid && b_ready;

  // --- mode register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mmp_pkg::MODE_FIB;
    end else if (cfg_we) begin
      mode <= mmp_pkg::mode_t'(cfg_wdata);
    end
  end

  // --- stage A ---
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_req.kind <= mmp_pkg::req_kind_t'(req_type);
      a_req.seed <= seed;
    end
  end

  // --- generator state and update ---
  mmp_gen u_gen (
    .clk  (clk),
    .rst  (rst),
    .mode (mode),
    .fire (fire),
    .req  (a_req),
    .raw  (raw)
  );

  // --- stage B: only next-value items continue ---
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= fire && (a_req.kind == mmp_pkg::REQ_NEXT);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_raw <= raw;
      b_lcg <= (mode == mmp_pkg::MODE_LCG);
    end
  end

  // --- stage C: output register, LCG values folded mod 65535 ---
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      value <= b_lcg ? mmp_pkg::mod_ffff(b_raw) : b_raw[15:0];
    end
  end

`ifndef SYNTHESIS
  // a seed load never yields a result
  a_seed_no_result: assert property (@(posedge clk) disable iff (rst)
    (fire && a_req.kind == mmp_pkg::REQ_SEED) |=> !b_valid)
    else $error("seed item produced a result");

  // input only stalls when every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && b_valid && out_valid))
    else $error("input stalled with room in the pipeline");

  // a new output must come from stage B
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_valid))
    else $error("output valid without a raw result");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for multi_mode_prng
// Seed and next-value items are driven through the valid/stall request port
// while the mode register is stepped through all four generators. A local
// copy of the generator state predicts every value at the moment its item is
// accepted. Returned values are checked in order against those predictions.
// Both sides insert random idle cycles, and some phases run without idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  // pipeline is three deep; a seed leaves nothing to wait on, so pad it
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned RANDOM_ITEMS = 1420;

  // seeds that the masked Galois mode refuses to load
  localparam logic [15:0] REJECTED_SEEDS [48] = '{
    16'h06d4, 16'h1744, 16'h19d0, 16'h1ccc, 16'h1cfa, 16'h1f79, 16'h2040, 16'h2ee4,
    16'h3362, 16'h3914, 16'h3ac4, 16'h3c25, 16'h4ee4, 16'h4fb9, 16'h56e4, 16'h57c4,
    16'h5c40, 16'h5ecc, 16'h653a, 16'h72d4, 16'h77ec, 16'h7bfa, 16'h82d4, 16'h8759,
    16'h8ad4, 16'h9744, 16'h9e40, 16'ha039, 16'ha0cc, 16'ha4cc, 16'ha704, 16'hac3a,
    16'hb6c4, 16'hbcc0, 16'hbdcc, 16'hbec4, 16'hc4d4, 16'hd2e4, 16'hd875, 16'hdac2,
    16'hdc7a, 16'hddfa, 16'he3d9, 16'he704, 16'hef04, 16'hef39, 16'hf8c4, 16'hfd40
  };

  // one pending item: payload, idle cycles before it, and whether the
  // sender must first see every outstanding value come back
  typedef struct {
    mmp_pkg::req_kind_t kind;
    logic [15:0]        seed_val;
    int unsigned        gap;
    bit                 hold;
  } prng_req_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_valid  = 1'b0;
  logic        req_type  = 1'b0;
  logic [15:0] seed      = 16'd0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [15:0] value;

  multi_mode_prng dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .seed      (seed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Generator copy: state after reset, advanced on every accepted item
  // --------------------------------------------------------------------------
  mmp_pkg::mode_t gen_mode  = mmp_pkg::MODE_FIB;
  logic [30:0]    gen_shift = 31'd1;
  logic [15:0]    gen_mask  = 16'd3973;   // 137*29
  logic [31:0]    gen_lcg   = 32'd1;

  prng_req_t   pending_reqs[$];
  logic [15:0] expected_values[$];

  // run flags and tallies
  bit          src_burst  = 1'b0;     // sender never idles
  bit          sink_burst = 1'b0;     // receiver never stalls
  int unsigned errors     = 0;
  int unsigned items_taken = 0;
  int unsigned seeds_taken = 0;
  int unsigned values_seen = 0;
  int unsigned mode_writes = 0;
  int unsigned cycles     = 0;

  function automatic bit seed_rejected(logic [15:0] s);
    bit hit;
    hit = 1'b0;
    foreach (REJECTED_SEEDS[i]) begin
      if (REJECTED_SEEDS[i] == s) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // A seed only touches the state of the mode in force
  function automatic void load_seed(logic [15:0] s);
    case (gen_mode)
      mmp_pkg::MODE_FIB: begin
        gen_shift = {15'd0, s};
      end
      mmp_pkg::MODE_LCG: begin
        gen_lcg = {16'd0, s};
      end
      mmp_pkg::MODE_GALOIS: begin
        if (!seed_rejected(s)) begin
          gen_shift = 31'(32'd14161 * {16'd0, s});   // 119*119*seed
          gen_mask  = 16'(32'd3973 * {16'd0, s});    // 137*29*seed
        end
      end
      default: begin
        gen_shift = {15'd0, s} + 31'd1;
      end
    endcase
  endfunction

  function automatic logic [15:0] step_generator();
    logic [15:0] t;
    logic        top;
    logic [63:0] prod;
    logic [31:0] r;
    case (gen_mode)
      mmp_pkg::MODE_FIB: begin
        // only the low 16 bits count; feedback is parity of taps 16,15,13,4
        t = gen_shift[15:0];
        t = {t[14:0], t[15] ^ t[14] ^ t[12] ^ t[3]};
        gen_shift = {15'd0, t};
        return t;
      end
      mmp_pkg::MODE_LCG: begin
        gen_lcg = gen_lcg * 32'd1103515245 + 32'd12345;
        return 16'(gen_lcg % 32'd65535);
      end
      mmp_pkg::MODE_GALOIS: begin
        t   = gen_shift[15:0];
        top = t[15];
        t   = t << 1;
        if (top) begin
          t = t ^ 16'h100B;
        end
        t = t + 16'd1;
        gen_shift = {15'd0, t};
        return t ^ gen_mask;
      end
      default: begin
        // Park-Miller: fold the 33614 product back into 31 bits
        prod = 64'd33614 * {33'd0, gen_shift};
        r    = {1'b0, prod[31:1]} + prod[63:32];
        if (r[31]) begin
          r = {1'b0, r[30:0]} + 32'd1;
        end
        gen_shift = r[30:0];
        return r[15:0];
      end
    endcase
  endfunction

  function automatic void accept_request(mmp_pkg::req_kind_t k, logic [15:0] s);
    items_taken++;
    if (k == mmp_pkg::REQ_SEED) begin
      seeds_taken++;
      load_seed(s);
    end else begin
      expected_values.push_back(step_generator());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: pops pending items, honors per-item gaps and hold points
  // --------------------------------------------------------------------------
  int unsigned idle_left = 0;
  bit          gap_armed = 1'b0;

  always @(posedge clk) begin : drive_requests
    logic      nxt_valid;
    prng_req_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        accept_request(mmp_pkg::req_kind_t'(req_type), seed);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_reqs.size() > 0) begin
        if (!gap_armed) begin
          idle_left = pending_reqs[0].gap;
          gap_armed = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
        end else if (!pending_reqs[0].hold || expected_values.size() == 0) begin
          it = pending_reqs.pop_front();
          req_type  <= it.kind;
          seed      <= it.seed_val;
          nxt_valid = 1'b1;
          gap_armed = 1'b0;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Value monitor: in-order compare, random back-pressure after each value
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk) begin : check_values
    logic [15:0] want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        values_seen++;
        if (expected_values.size() == 0) begin
          errors++;
          $display("%0t: unexpected value: expected none, got %h", $time, value);
        end else begin
          want = expected_values.pop_front();
          if (value !== want) begin
            errors++;
            $display("%0t: value mismatch: expected %h, got %h", $time, want, value);
          end
        end
        stall_left = sink_burst ? 0 : $urandom_range(7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d values outstanding",
               cycles, expected_values.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_req(mmp_pkg::req_kind_t k, logic [15:0] s, bit hold);
    prng_req_t it;
    it.kind     = k;
    it.seed_val = s;
    it.gap      = src_burst ? 0 : $urandom_range(7);
    it.hold     = hold;
    pending_reqs.push_back(it);
  endfunction

  function automatic logic [15:0] pick_seed();
    case ($urandom_range(9))
      0:       return REJECTED_SEEDS[$urandom_range(47)];
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // wait until nothing is queued, in flight or owed, then let the pipe empty
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_values.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(mmp_pkg::mode_t m);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    gen_mode  = m;
    mode_writes++;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned    random_sent;
    int unsigned    ph;
    int unsigned    n;
    mmp_pkg::mode_t m;
    random_sent = 0;
    ph          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset state of Fibonacci, stuck-at-zero seed, all-ones seed
    queue_req(mmp_pkg::REQ_NEXT, 16'hFFFF, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h5A5A, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'hFFFF, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);

    // LCG from its reset state, then both seed extremes
    set_mode(mmp_pkg::MODE_LCG);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'hFFFF, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);

    // Galois with reset mask, a refused seed, then the seed extremes
    set_mode(mmp_pkg::MODE_GALOIS);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'h06d4, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'hFFFF, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_SEED, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);

    // Park-Miller builds a wide state; Galois must drop the upper bits
    set_mode(mmp_pkg::MODE_PM);
    queue_req(mmp_pkg::REQ_SEED, 16'hFFFF, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    set_mode(mmp_pkg::MODE_GALOIS);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);

    // zero handed over from Fibonacci is a Park-Miller fixed point
    set_mode(mmp_pkg::MODE_FIB);
    queue_req(mmp_pkg::REQ_SEED, 16'h0000, 1'b0);
    set_mode(mmp_pkg::MODE_PM);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);
    queue_req(mmp_pkg::REQ_NEXT, 16'h0000, 1'b0);

    // Random phases: first pass walks every mode, extremes included;
    // some phases run one or both sides without idle cycles
    while (random_sent < RANDOM_ITEMS) begin
      m = (ph < 4) ? mmp_pkg::mode_t'(3 - ph) : mmp_pkg::mode_t'($urandom_range(3));
      set_mode(m);
      src_burst  = (ph % 3 == 1);
      sink_burst = (ph % 4 == 2);
      n = $urandom_range(60, 160);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) begin
          queue_req(mmp_pkg::REQ_SEED, pick_seed(), i == n / 2);
        end else begin
          // seed field is don't-care here; drive junk to prove it
          queue_req(mmp_pkg::REQ_NEXT, 16'($urandom), i == n / 2);
        end
      end
      random_sent += n;
      ph++;
    end

    wait_idle();
    if (expected_values.size() != 0) begin
      errors++;
      $display("%0t: %0d expected values never arrived", $time, expected_values.size());
    end

    $display("Ran %0d items (%0d seed loads) across %0d mode settings in %0d phases",
             items_taken, seeds_taken, mode_writes, ph);
    $display("Checked %0d generated values, %0d mismatches", values_seen, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
